FILE: rtl/rtcp_pkg.sv
// Shared types and constants for the RTC parameter RAM command engine.
package rtcp_pkg;

    // Parameter RAM size and the fixed address width of the command format
    localparam int unsigned RAM_DEPTH_DEF = 256;
    localparam int unsigned ADDR_W        = 8;

    // Packed stream widths (whole bytes)
    localparam int unsigned IN_DATA_W  = 24;
    localparam int unsigned OUT_DATA_W = 48;
    localparam int unsigned OUT_PAD_W  = 6;

    // Configuration register reset values
    localparam logic [7:0] TICK_INC_RST   = 8'd2;
    localparam logic [7:0] TICK_MATCH_RST = 8'd125;

    // Regular address map
    localparam logic [3:0] EXT_PREFIX = 4'h7;   // regular address 0x0E or 0x0F
    localparam logic [4:0] SEC_LAST   = 5'h07;
    localparam logic [4:0] RAM_A_LO   = 5'h08;
    localparam logic [4:0] RAM_A_HI   = 5'h0B;
    localparam logic [4:0] WP_ADDR    = 5'h0D;
    localparam logic [7:0] RD_NONE    = 8'hFF;

    // Item kinds carried on tuser
    typedef enum logic {
        KIND_TICK = 1'b0,
        KIND_CMD  = 1'b1
    } t_kind;

    // Configuration register indexes
    typedef enum logic {
        CFG_TICK_INC   = 1'b0,
        CFG_TICK_MATCH = 1'b1
    } t_cfg_idx;

    // Parameter RAM access request from the command decoder
    typedef struct packed {
        logic              rd_en;
        logic              wr_en;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        wdata;
    } t_ram_req;

    // Result word before the RAM read data is merged in
    typedef struct packed {
        logic        ram_sel;
        logic [7:0]  rd_byte;
        logic        line;
        logic [31:0] seconds;
        logic        flush;
    } t_result;

endpackage

FILE: rtl/rtcp_ram.sv
// Generic single-port-write, registered-read RAM.
module rtcp_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/rtcp_pram.sv
// Parameter RAM with per-entry valid bits so unwritten bytes read as zero.
module rtcp_pram #(
    parameter int unsigned RAM_DEPTH = rtcp_pkg::RAM_DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  rtcp_pkg::t_ram_req i_req,
    output logic [7:0]         o_rdata
);

    localparam int unsigned AW = $clog2(RAM_DEPTH);

    logic [RAM_DEPTH-1:0] r_valid;
    logic                 r_rd_valid;
    logic [7:0]           ram_q;
    logic [AW-1:0]        addr;

    assign addr = i_req.addr[AW-1:0];

    rtcp_ram #(
        .WIDTH(8),
        .DEPTH(RAM_DEPTH)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (i_req.wr_en),
        .i_waddr(addr),
        .i_wdata(i_req.wdata),
        .i_re   (i_req.rd_en),
        .i_raddr(addr),
        .o_rdata(ram_q)
    );

    // Valid bits: reset clears all, a write marks its entry.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_req.wr_en) begin
            r_valid[addr] <= 1'b1;
        end
    end

    // Valid flag of the entry being read travels with the read data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_valid <= 1'b0;
        end else if (i_req.rd_en) begin
            r_rd_valid <= r_valid[addr];
        end
    end

    assign o_rdata = r_rd_valid ? ram_q : 8'h00;

endmodule

FILE: rtl/rtcp_state.sv
// Tick divider, seconds counter, write protect and command decode.
module rtcp_state (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic               i_cfg_index,
    input  logic [7:0]         i_cfg_data,
    input  logic               i_accept,
    input  logic               i_kind,
    input  logic [7:0]         i_command_byte,
    input  logic [7:0]         i_extended_byte,
    input  logic [7:0]         i_write_data,
    output rtcp_pkg::t_ram_req o_req,
    output rtcp_pkg::t_result  o_res
);

    logic [7:0]  r_tick_inc;
    logic [7:0]  r_tick_match;
    logic [7:0]  r_acc;
    logic        r_level;
    logic [31:0] r_sec;
    logic        r_wp;

    logic [7:0]  n_acc;
    logic        n_level;
    logic [31:0] n_sec;
    logic        n_wp;

    logic [7:0]  acc_sum;
    logic        is_write;
    logic [4:0]  reg_addr;
    logic        reg_is_ram;
    logic [4:0]  byte_sh;

    assign acc_sum    = r_acc + r_tick_inc;
    assign is_write   = ~i_command_byte[7];
    assign reg_addr   = i_command_byte[6:2];
    assign reg_is_ram = ((reg_addr >= rtcp_pkg::RAM_A_LO) && (reg_addr <= rtcp_pkg::RAM_A_HI))
                        || reg_addr[4];
    assign byte_sh    = {reg_addr[1:0], 3'b000};

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick_inc   <= rtcp_pkg::TICK_INC_RST;
            r_tick_match <= rtcp_pkg::TICK_MATCH_RST;
        end else if (i_cfg_we) begin
            unique case (rtcp_pkg::t_cfg_idx'(i_cfg_index))
                rtcp_pkg::CFG_TICK_INC:   r_tick_inc   <= i_cfg_data;
                rtcp_pkg::CFG_TICK_MATCH: r_tick_match <= i_cfg_data;
                default:                  r_tick_inc   <= r_tick_inc;
            endcase
        end
    end

    // Next state, RAM request and result for the accepted word
    always_comb begin
        n_acc         = r_acc;
        n_level       = r_level;
        n_sec         = r_sec;
        n_wp          = r_wp;
        o_req.rd_en   = 1'b0;
        o_req.wr_en   = 1'b0;
        o_req.addr    = {3'b000, reg_addr};
        o_req.wdata   = i_write_data;
        o_res.ram_sel = 1'b0;
        o_res.rd_byte = rtcp_pkg::RD_NONE;
        o_res.flush   = 1'b0;
        if (i_accept) begin
            if (rtcp_pkg::t_kind'(i_kind) == rtcp_pkg::KIND_TICK) begin
                // Timer tick: accumulate and toggle the square wave at the match.
                n_acc = acc_sum;
                if (acc_sum >= r_tick_match) begin
                    n_level = ~r_level;
                    n_acc   = acc_sum - r_tick_match;
                    if (!r_level) begin
                        n_sec = r_sec + 32'd1;
                    end
                end
            end else if (i_command_byte[6:3] == rtcp_pkg::EXT_PREFIX) begin
                // Extended command: 8-bit RAM address from both bytes.
                o_req.addr = {i_command_byte[2:0], i_extended_byte[6:2]};
                if (is_write) begin
                    o_req.wr_en = ~r_wp;
                end else begin
                    o_req.rd_en   = 1'b1;
                    o_res.ram_sel = 1'b1;
                end
            end else if (is_write) begin
                // Regular write; only write protect itself passes while protected.
                if (!r_wp || reg_addr == rtcp_pkg::WP_ADDR) begin
                    if (reg_addr <= rtcp_pkg::SEC_LAST) begin
                        n_sec[byte_sh +: 8] = i_write_data;
                    end else if (reg_addr == rtcp_pkg::WP_ADDR) begin
                        o_res.flush = ~r_wp & i_write_data[7];
                        n_wp        = i_write_data[7];
                    end else if (reg_is_ram) begin
                        o_req.wr_en = 1'b1;
                    end
                end
            end else begin
                // Regular read
                if (reg_addr <= rtcp_pkg::SEC_LAST) begin
                    o_res.rd_byte = r_sec[byte_sh +: 8];
                end else if (reg_is_ram) begin
                    o_req.rd_en   = 1'b1;
                    o_res.ram_sel = 1'b1;
                end
            end
        end
        o_res.line    = n_level;
        o_res.seconds = n_sec;
    end

    // Clock state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc   <= 8'd0;
            r_level <= 1'b0;
            r_sec   <= 32'd0;
            r_wp    <= 1'b1;
        end else begin
            r_acc   <= n_acc;
            r_level <= n_level;
            r_sec   <= n_sec;
            r_wp    <= n_wp;
        end
    end

endmodule

FILE: rtl/rtc_pram_command_engine.sv
// Top level of the RTC parameter RAM command engine.
// An accepted input word's result word is registered and offered on the master side in the next cycle.
// Throughput: one word per cycle while the result side takes words; the registered RAM read and the result register
// line up so that consecutive commands never wait on each other.
// Reset (synchronous, active low): seconds, accumulator and wave cleared, write protect
// set, tick registers at 2 and 125; the RAM reads zero via per-entry valid bits.
module rtc_pram_command_engine #(
    parameter int unsigned RAM_DEPTH = rtcp_pkg::RAM_DEPTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // Configuration write port
    input  logic                               i_cfg_we,
    input  logic                               i_cfg_index,
    input  logic [7:0]                         i_cfg_data,
    // Input stream
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    input  logic [rtcp_pkg::IN_DATA_W-1:0]     i_s_tdata,  // command_byte, extended_byte, write_data
    input  logic                               i_s_tuser,  // kind
    // Result stream
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    output logic [rtcp_pkg::OUT_DATA_W-1:0]    o_m_tdata   // read_data, one_second_line,
                                                           // seconds_value, flush_request, pad
);

    logic               accept;
    rtcp_pkg::t_ram_req ram_req;
    rtcp_pkg::t_result  res_next;
    rtcp_pkg::t_result  r_res;
    logic               r_out_valid;
    logic [7:0]         ram_rdata;
    logic [7:0]         read_data;

    assign o_s_tready = ~r_out_valid | i_m_tready;
    assign accept     = i_s_tvalid & o_s_tready;

    rtcp_state u_state (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_accept       (accept),
        .i_kind         (i_s_tuser),
        .i_command_byte (i_s_tdata[7:0]),
        .i_extended_byte(i_s_tdata[15:8]),
        .i_write_data   (i_s_tdata[23:16]),
        .o_req          (ram_req),
        .o_res          (res_next)
    );

    rtcp_pram #(
        .RAM_DEPTH(RAM_DEPTH)
    ) u_pram (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (ram_req),
        .o_rdata(ram_rdata)
    );

    // Result register; the RAM read data register holds alongside it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_out_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_res <= res_next;
        end
    end

    assign read_data  = r_res.ram_sel ? ram_rdata : r_res.rd_byte;
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{rtcp_pkg::OUT_PAD_W{1'b0}}, r_res.flush, r_res.seconds,
                         r_res.line, read_data};

endmodule

FILE: rtl/rtcp_checker.sv
// Port-level checker for the RTC parameter RAM command engine, bound to the top level.
module rtcp_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_s_tvalid,
    input logic                            o_s_tready,
    input logic                            o_m_tvalid,
    input logic                            i_m_tready,
    input logic [rtcp_pkg::OUT_DATA_W-1:0] o_m_tdata
);

    // No result word is offered in the cycle after reset.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid right after reset");

    // An accepted input word shows up as a result word in the next cycle.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> o_m_tvalid)
        else $error("accepted word produced no result");

    // A stalled result word holds.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> (o_m_tvalid && $stable(o_m_tdata)))
        else $error("stalled result changed");

    // A backup request comes only from a write, which reads back 0xFF.
    a_flush_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tdata[41]) |-> (o_m_tdata[7:0] == rtcp_pkg::RD_NONE))
        else $error("flush request on a read result");

endmodule

bind rtc_pram_command_engine rtcp_checker u_rtcp_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .i_s_tvalid(i_s_tvalid),
    .o_s_tready(o_s_tready),
    .o_m_tvalid(o_m_tvalid),
    .i_m_tready(i_m_tready),
    .o_m_tdata (o_m_tdata)
);

FILE: tb/sv/rtc_pram_command_engine_tb.sv
// Self-checking testbench for the RTC parameter RAM command engine.
`timescale 1ns / 100ps

module rtc_pram_command_engine_tb;

    // Command direction flag in bit 7 of the command byte
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_READ  = 1'b1;
    // Regular address of the test register, which is write-only and not modeled
    localparam logic [4:0] TEST_ADDR = 5'h0C;
    // Start of the upper regular RAM window
    localparam logic [4:0] RAM_B_LO = 5'h10;
    localparam int CYCLE_LIMIT = 100000;
    localparam int PRINT_LIMIT = 40;

    // One result word as the engine returns it
    typedef struct packed {
        logic [7:0]  rd_byte;
        logic        line;
        logic [31:0] seconds;
        logic        flush;
    } t_rtc_reply;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n;
    logic                            i_cfg_we;
    logic                            i_cfg_index;
    logic [7:0]                      i_cfg_data;
    logic                            i_s_tvalid;
    logic                            o_s_tready;
    logic [rtcp_pkg::IN_DATA_W-1:0]  i_s_tdata;   // command_byte, extended_byte, write_data
    logic                            i_s_tuser;   // kind
    logic                            o_m_tvalid;
    logic                            i_m_tready;
    logic [rtcp_pkg::OUT_DATA_W-1:0] o_m_tdata;   // read_data, one_second_line,
                                                  // seconds_value, flush_request, pad

    // Clock state copy used for prediction
    logic [7:0]  cfg_inc;
    logic [7:0]  cfg_match;
    logic [31:0] sec_count;
    logic [7:0]  pram [0:rtcp_pkg::RAM_DEPTH_DEF-1];
    logic        wp_on;
    logic [7:0]  frac_acc;
    logic        sq_level;

    t_rtc_reply expected_replies [$];
    int errors = 0;
    int cycles = 0;
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;

    rtc_pram_command_engine i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata)
    );

    // 10 ns clock.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Advance the clock model by one word and return the reply it should produce.
    function automatic t_rtc_reply rtc_apply(input rtcp_pkg::t_kind kind_i,
                                             input logic [7:0] cmd,
                                             input logic [7:0] ext, input logic [7:0] wd);
        t_rtc_reply r;
        logic [4:0] a;
        logic [7:0] ea;
        logic       in_pram;
        r.rd_byte = rtcp_pkg::RD_NONE;
        r.flush   = 1'b0;
        a         = cmd[6:2];
        ea        = {cmd[2:0], ext[6:2]};
        in_pram   = (a >= rtcp_pkg::RAM_A_LO && a <= rtcp_pkg::RAM_A_HI) || a[4];
        if (kind_i == rtcp_pkg::KIND_TICK) begin
            frac_acc = frac_acc + cfg_inc;
            if (frac_acc >= cfg_match) begin
                sq_level = ~sq_level;
                if (sq_level)
                    sec_count = sec_count + 32'd1;
                frac_acc = frac_acc - cfg_match;
            end
        end else if (cmd[6:3] == rtcp_pkg::EXT_PREFIX) begin
            // Extended address: three bits from the command, five from the second byte.
            if (cmd[7] == OP_WRITE) begin
                if (!wp_on)
                    pram[ea] = wd;
            end else begin
                r.rd_byte = pram[ea];
            end
        end else if (cmd[7] == OP_WRITE) begin
            // The protect flag itself stays writable while protected.
            if (a == rtcp_pkg::WP_ADDR) begin
                r.flush = !wp_on && wd[7];
                wp_on   = wd[7];
            end else if (!wp_on) begin
                if (a <= rtcp_pkg::SEC_LAST)
                    sec_count[8*a[1:0] +: 8] = wd;
                else if (in_pram)
                    pram[a] = wd;
            end
        end else begin
            if (a <= rtcp_pkg::SEC_LAST)
                r.rd_byte = sec_count[8*a[1:0] +: 8];
            else if (in_pram)
                r.rd_byte = pram[a];
        end
        r.line    = sq_level;
        r.seconds = sec_count;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        errors++;
        if (errors <= PRINT_LIMIT)
            $display("MISMATCH %s: got 0x%0h, want 0x%0h (cycle %0d)", what, got, want, cycles);
    endtask

    // Present one word, with random idle cycles ahead of it, and predict its reply.
    task automatic send_word(input rtcp_pkg::t_kind kind_i, input logic [7:0] cmd,
                             input logic [7:0] ext, input logic [7:0] wd);
        while ($urandom_range(99) < tx_idle_pct) begin
            @(negedge i_clk);
            i_s_tvalid <= 1'b0;
        end
        @(negedge i_clk);
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= kind_i;
        i_s_tdata  <= {wd, ext, cmd};
        do
            @(posedge i_clk);
        while (!o_s_tready);
        expected_replies.push_back(rtc_apply(kind_i, cmd, ext, wd));
    endtask

    // Tick with random junk in the unused command fields.
    task automatic send_tick();
        send_word(rtcp_pkg::KIND_TICK, 8'($urandom), 8'($urandom), 8'($urandom));
    endtask

    // Regular command; the low two bits of the command byte and the second byte are noise.
    task automatic send_reg(input logic op, input logic [4:0] a, input logic [7:0] wd);
        logic [1:0] low_bits;
        low_bits = 2'($urandom_range(3));
        send_word(rtcp_pkg::KIND_CMD, {op, a, low_bits}, 8'($urandom), wd);
    endtask

    // Extended command; bit 7 and bits 1..0 of the second byte are noise.
    task automatic send_ext(input logic op, input logic [7:0] ea, input logic [7:0] wd);
        logic [2:0] noise;
        noise = 3'($urandom_range(7));
        send_word(rtcp_pkg::KIND_CMD, {op, rtcp_pkg::EXT_PREFIX, ea[7:5]},
                  {noise[2], ea[4:0], noise[1:0]}, wd);
    endtask

    // Hold the sender off until every pending reply has come back.
    task automatic wait_for_results();
        @(negedge i_clk);
        i_s_tvalid <= 1'b0;
        while (expected_replies.size() != 0)
            @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    // Register writes happen only with the engine drained.
    task automatic write_reg(input rtcp_pkg::t_cfg_idx idx, input logic [7:0] v);
        wait_for_results();
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= v;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        if (idx == rtcp_pkg::CFG_TICK_INC)
            cfg_inc = v;
        else
            cfg_match = v;
    endtask

    function automatic logic [7:0] pick_reg_value();
        case ($urandom_range(5))
            0:       return 8'd0;
            1:       return 8'd1;
            2:       return 8'd255;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    // Reads straight after reset and a tick at the default rate.
    task automatic test_reset_state();
        send_reg(OP_READ, 5'h00, 8'h00);
        send_ext(OP_READ, 8'hFF, 8'h00);
        send_tick();
    endtask

    // Writes bounce while protected; clearing and setting the flag, with the flush pulse.
    task automatic test_write_protect();
        send_reg(OP_WRITE, 5'h03, 8'hFF);
        send_ext(OP_WRITE, 8'h80, 8'h11);
        send_reg(OP_WRITE, RAM_B_LO, 8'h22);
        send_reg(OP_WRITE, rtcp_pkg::WP_ADDR, 8'h7F);
        send_reg(OP_WRITE, rtcp_pkg::WP_ADDR, 8'h80);
        send_reg(OP_WRITE, rtcp_pkg::WP_ADDR, 8'hFF);
        send_reg(OP_WRITE, rtcp_pkg::WP_ADDR, 8'h00);
    endtask

    // Address map edges, aliasing between the two address forms, unmapped reads.
    task automatic test_address_map();
        send_ext(OP_WRITE, 8'hFF, 8'hA5);
        send_ext(OP_READ, 8'hFF, 8'h00);
        send_reg(OP_WRITE, 5'h1F, 8'h00);
        send_ext(OP_READ, 8'h1F, 8'h00);
        send_reg(OP_WRITE, rtcp_pkg::RAM_A_HI, 8'h3C);
        send_ext(OP_READ, 8'h0B, 8'h00);
        send_reg(OP_READ, rtcp_pkg::RAM_A_LO, 8'h00);
        send_reg(OP_WRITE, TEST_ADDR, 8'h77);
        send_reg(OP_READ, TEST_ADDR, 8'h00);
        send_reg(OP_READ, rtcp_pkg::WP_ADDR, 8'h00);
        // Upper seconds aliases set every byte to all ones for the wrap check.
        for (int i = 4; i <= 7; i++)
            send_reg(OP_WRITE, 5'(i), 8'hFF);
        send_reg(OP_READ, 5'h02, 8'h00);
    endtask

    // Zero match, zero increment, accumulator wrap and seconds wrap.
    task automatic test_tick_settings();
        write_reg(rtcp_pkg::CFG_TICK_INC, 8'd0);
        write_reg(rtcp_pkg::CFG_TICK_MATCH, 8'd0);
        send_tick();
        send_tick();
        write_reg(rtcp_pkg::CFG_TICK_INC, 8'd255);
        write_reg(rtcp_pkg::CFG_TICK_MATCH, 8'd255);
        send_tick();
        write_reg(rtcp_pkg::CFG_TICK_MATCH, 8'd1);
        send_tick();
        send_tick();
        write_reg(rtcp_pkg::CFG_TICK_INC, 8'd1);
        write_reg(rtcp_pkg::CFG_TICK_MATCH, 8'd255);
        send_tick();
    endtask

    // Mostly well-formed commands to mapped places, with ticks and raw noise mixed in.
    task automatic send_random_word();
        int         sel;
        logic       op;
        logic [7:0] wd;
        sel = $urandom_range(99);
        op  = 1'($urandom_range(1));
        wd  = 8'($urandom);
        if (sel < 25)
            send_tick();
        else if (sel < 35)
            send_word(rtcp_pkg::KIND_CMD, 8'($urandom), 8'($urandom), wd);
        else if (sel < 45)
            send_reg(OP_WRITE, rtcp_pkg::WP_ADDR,
                     ($urandom_range(99) < 25) ? (wd | 8'h80) : (wd & 8'h7F));
        else if (sel < 60)
            send_reg(op, 5'($urandom_range(7)), wd);
        else if (sel < 80)
            send_reg(op, ($urandom_range(3) == 0)
                         ? rtcp_pkg::RAM_A_LO + 5'($urandom_range(3))
                         : RAM_B_LO + 5'($urandom_range(15)), wd);
        else if (sel < 95)
            send_ext(op, 8'($urandom), wd);
        else
            send_reg(op, TEST_ADDR, wd);
    endtask

    task automatic test_random_traffic(input int tx_pct, input int rx_pct);
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        for (int s = 0; s < 4; s++) begin
            write_reg(rtcp_pkg::CFG_TICK_INC, pick_reg_value());
            write_reg(rtcp_pkg::CFG_TICK_MATCH, pick_reg_value());
            for (int i = 0; i < 66; i++) begin
                send_random_word();
                if (i == 33)
                    wait_for_results();
            end
        end
    endtask

    // Result side: random back-pressure.
    always @(negedge i_clk) begin
        i_m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // Compare every accepted result word with the oldest prediction.
    always @(posedge i_clk) begin : check_reply
        t_rtc_reply want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (expected_replies.size() == 0) begin
                report_mismatch("result word with nothing pending", o_m_tdata[31:0], 32'd0);
            end else begin
                want = expected_replies.pop_front();
                if (o_m_tdata[7:0] !== want.rd_byte)
                    report_mismatch("read_data", 32'(o_m_tdata[7:0]), 32'(want.rd_byte));
                if (o_m_tdata[8] !== want.line)
                    report_mismatch("one_second_line", 32'(o_m_tdata[8]), 32'(want.line));
                if (o_m_tdata[40:9] !== want.seconds)
                    report_mismatch("seconds_value", o_m_tdata[40:9], want.seconds);
                if (o_m_tdata[41] !== want.flush)
                    report_mismatch("flush_request", 32'(o_m_tdata[41]), 32'(want.flush));
            end
        end
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_index = rtcp_pkg::CFG_TICK_INC;
        i_cfg_data  = 8'h00;
        i_s_tvalid  = 1'b0;
        i_s_tdata   = '0;
        i_s_tuser   = rtcp_pkg::KIND_TICK;
        // Model state after reset.
        cfg_inc   = rtcp_pkg::TICK_INC_RST;
        cfg_match = rtcp_pkg::TICK_MATCH_RST;
        sec_count = 32'd0;
        wp_on     = 1'b1;
        frac_acc  = 8'd0;
        sq_level  = 1'b0;
        for (int i = 0; i < rtcp_pkg::RAM_DEPTH_DEF; i++)
            pram[i] = 8'h00;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        tx_idle_pct = 37;
        rx_idle_pct = 70;
        test_reset_state();
        test_write_protect();
        test_address_map();
        test_tick_settings();
        test_random_traffic(37, 70);
        test_random_traffic(70, 37);
        test_random_traffic(0, 0);

        wait_for_results();
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
